@@ hdl/wpd_pkg.sv @@
// Package of the waveform peak decimator: field widths, register indexes, sample
// formats, reset values and float32 conversion constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package wpd_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int PEAK_W      = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int FMT_W       = 2;
	localparam int CHAN_W      = 4;
	localparam int FPP_W       = 32;
	localparam int MAXPTS_W    = 11;

	localparam int DEFAULT_MAX_CHANNELS = 8;
	localparam int DEFAULT_POINT_LIMIT  = 1024;

	typedef logic [SAMPLE_W-1:0]   word_t;
	typedef logic [PEAK_W-1:0]     peak_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Full scale amplitude, 1.0 in unsigned Q1.16.
	localparam peak_t FULL_SCALE = 17'h1_0000;

	typedef enum logic [FMT_W-1:0] {
		FMT_U8  = 2'd0,
		FMT_S16 = 2'd1,
		FMT_S32 = 2'd2,
		FMT_F32 = 2'd3
	} fmt_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_FORMAT    = 2'd0,
		REG_CHANNEL_COUNT    = 2'd1,
		REG_FRAMES_PER_POINT = 2'd2,
		REG_MAX_POINTS       = 2'd3
	} reg_index_t;

	localparam fmt_t                RST_SAMPLE_FORMAT    = FMT_S16;
	localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT    = 4'd2;
	localparam logic [FPP_W-1:0]    RST_FRAMES_PER_POINT = 32'd1;
	localparam logic [MAXPTS_W-1:0] RST_MAX_POINTS       = 11'd900;

	// float32 fields and the exponent window that maps onto Q1.16.
	localparam logic [7:0] F32_EXP_SPECIAL = 8'hFF;
	localparam logic [7:0] F32_EXP_ONE     = 8'd127;
	localparam logic [7:0] F32_EXP_MIN     = 8'd103;
	localparam logic [7:0] F32_SHIFT_BASE  = 8'd134;

	// Offset of unsigned 8-bit audio.
	localparam logic [7:0] U8_MIDPOINT = 8'd128;

endpackage

`default_nettype wire

@@ hdl/wpd_if.sv @@
// Channel interfaces of the waveform peak decimator: sample input, peak point
// output and configuration write channel. Depends on wpd_pkg.
`default_nettype none

interface wpd_sample_if;
	import wpd_pkg::*;
	logic  valid;
	logic  ready;
	word_t sample_word;
	logic  end_of_track;
	modport source (output valid, output sample_word, output end_of_track, input ready);
	modport sink (input valid, input sample_word, input end_of_track, output ready);
endinterface

interface wpd_point_if;
	import wpd_pkg::*;
	logic  valid;
	logic  ready;
	peak_t peak_level;
	logic  final_point;
	modport source (output valid, output peak_level, output final_point, input ready);
	modport sink (input valid, input peak_level, input final_point, output ready);
endinterface

interface wpd_cfg_if;
	import wpd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	cfg_data_t              data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/wpd_amplitude.sv @@
// Sample word to absolute amplitude in unsigned Q1.16, for all four formats.
// Purely combinational. Depends on wpd_pkg.
`default_nettype none

module wpd_amplitude (
	input  wpd_pkg::fmt_t  fmt,
	input  wpd_pkg::word_t word,
	output wpd_pkg::peak_t level
);
	import wpd_pkg::*;

	logic [7:0]  u8_byte;
	logic [7:0]  u8_dist;
	logic [15:0] s16_mag;
	word_t       s32_mag;
	logic [7:0]  f_exp;
	logic [22:0] f_man;
	logic [7:0]  f_shift_full;
	logic [4:0]  f_shift;
	logic [23:0] f_shifted;
	peak_t       f_level;

	assign u8_byte = word[7:0];
	assign u8_dist = (u8_byte >= U8_MIDPOINT) ? (u8_byte - U8_MIDPOINT)
	                                          : (U8_MIDPOINT - u8_byte);

	// Two's complement negation keeps -32768 at 0x8000, which doubles to full scale.
	assign s16_mag = word[15] ? (~word[15:0] + 16'd1) : word[15:0];
	assign s32_mag = word[31] ? (~word + 32'd1) : word;

	assign f_exp        = word[30:23];
	assign f_man        = word[22:0];
	assign f_shift_full = F32_SHIFT_BASE - f_exp;
	assign f_shift      = f_shift_full[4:0];
	assign f_shifted    = {1'b1, f_man} >> f_shift;

	// Only exponents in the window below one reach the shifter; the shift is then
	// at least eight, so the result stays below full scale.
	always_comb begin
		if (f_exp == F32_EXP_SPECIAL) begin
			f_level = (f_man != '0) ? '0 : FULL_SCALE;
		end else if (f_exp >= F32_EXP_ONE) begin
			f_level = FULL_SCALE;
		end else if (f_exp < F32_EXP_MIN) begin
			f_level = '0;
		end else begin
			f_level = f_shifted[PEAK_W-1:0];
		end
	end

	always_comb begin
		case (fmt)
			FMT_U8:  level = {u8_dist, 9'd0};
			FMT_S16: level = {s16_mag, 1'b0};
			FMT_S32: level = s32_mag[31:15];
			FMT_F32: level = f_level;
			default: level = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/waveform_peak_decimator.sv @@
// Top level of the waveform peak decimator: configuration registers, sample
// register, per-sample peak and counter update, and output register.
// Depends on wpd_pkg, the interfaces in wpd_if.sv and wpd_amplitude.
`default_nettype none

// The block takes one interleaved PCM sample per transaction and reduces a
// bucket of frames to one peak point, the largest absolute amplitude seen over
// all channels of the bucket, in unsigned Q1.16 where 65536 is 1.0. A point is
// sent when the bucket holds frames_per_point complete frames, and on the
// sample marked end_of_track, which flushes the current bucket (a cut
// short last frame counts) with final_point set. Once max_points points have
// been sent the last of them carries final_point, and further samples are
// swallowed without output up to and including the next end_of_track sample,
// which readies the block for a new track. Rate: one sample is taken on every
// clock while the point channel keeps up; a sample is held in the input
// register and its point, if any, is loaded into the output register as
// the sample moves on. The pace is set by the update of the running peak
// and the channel, frame and point counters, which every sample must pass
// before the next. Stalls on the point channel hold the input register; one
// further sample is still accepted while a finished point waits. Configuration
// writes are taken at once and act from the next sample on; they are meant to
// be made with no sample in flight. Zero register values act as one, and
// channel counts and point limits above the MAX_CHANNELS and POINT_LIMIT
// parameters saturate at them.
module waveform_peak_decimator #(
	parameter int MAX_CHANNELS = wpd_pkg::DEFAULT_MAX_CHANNELS,
	parameter int POINT_LIMIT  = wpd_pkg::DEFAULT_POINT_LIMIT
) (
	input  logic         clk,
	input  logic         arst_n,
	wpd_cfg_if.sink      cfg,
	wpd_sample_if.sink   samples,
	wpd_point_if.source  points
);
	import wpd_pkg::*;

	// Channel position counts 0 .. MAX_CHANNELS-1; comparisons run at a width
	// that holds both the position plus one and the channel_count register.
	localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
	localparam int CHC_W  = (CH_W > CHAN_W) ? CH_W : CHAN_W;
	// Points emitted count up to POINT_LIMIT.
	localparam int PTS_W  = $clog2(POINT_LIMIT + 1);
	localparam int PTC_W  = (PTS_W > MAXPTS_W) ? PTS_W : MAXPTS_W;

	localparam logic [CHC_W-1:0] CH_MAX = CHC_W'(MAX_CHANNELS);
	localparam logic [PTC_W-1:0] PT_MAX = PTC_W'(POINT_LIMIT);

	// Configuration registers.
	fmt_t                fmt_q;
	logic [CHAN_W-1:0]   chan_cnt_q;
	logic [FPP_W-1:0]    fpp_q;
	logic [MAXPTS_W-1:0] max_pts_q;

	// Input register.
	logic  valid_s1;
	word_t word_s1;
	logic  eot_s1;

	// Track state.
	peak_t            peak_q;
	logic [POS_W-1:0] pos_q;
	logic [FPP_W-1:0] frames_q;
	logic [PTS_W-1:0] pts_q;
	logic             track_done_q;

	// Output register.
	logic  out_valid_q;
	peak_t out_peak_q;
	logic  out_final_q;

	// Datapath of the sample held in the input register.
	peak_t            amp_s1;
	peak_t            peak_new;
	logic [CHC_W-1:0] chans_eff;
	logic [CHC_W-1:0] pos_inc;
	logic             frame_done;
	logic [FPP_W-1:0] frames_inc;
	logic             bucket_full;
	logic [PTC_W-1:0] limit_eff;
	logic [PTC_W-1:0] pts_inc;
	logic             emit;
	logic             fin;
	logic             advance;
	logic             step;

	// ------------------------------------------------------------------
	// Configuration channel: always ready, writes land immediately.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= RST_SAMPLE_FORMAT;
			chan_cnt_q <= RST_CHANNEL_COUNT;
			fpp_q      <= RST_FRAMES_PER_POINT;
			max_pts_q  <= RST_MAX_POINTS;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_index_t'(cfg.index))
				REG_SAMPLE_FORMAT:    fmt_q      <= fmt_t'(cfg.data[FMT_W-1:0]);
				REG_CHANNEL_COUNT:    chan_cnt_q <= cfg.data[CHAN_W-1:0];
				REG_FRAMES_PER_POINT: fpp_q      <= cfg.data[FPP_W-1:0];
				REG_MAX_POINTS:       max_pts_q  <= cfg.data[MAXPTS_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshakes. The held sample moves on whenever the output register is
	// free or is being emptied in this cycle, whether or not it makes a point.
	// ------------------------------------------------------------------
	assign advance       = !out_valid_q || points.ready;
	assign step          = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			word_s1 <= samples.sample_word;
			eot_s1  <= samples.end_of_track;
		end
	end

	// ------------------------------------------------------------------
	// Per-sample update.
	// ------------------------------------------------------------------
	wpd_amplitude u_amplitude (
		.fmt   (fmt_q),
		.word  (word_s1),
		.level (amp_s1)
	);

	assign peak_new = (amp_s1 > peak_q) ? amp_s1 : peak_q;

	always_comb begin
		if (chan_cnt_q == '0) begin
			chans_eff = CHC_W'(1);
		end else if (CHC_W'(chan_cnt_q) > CH_MAX) begin
			chans_eff = CH_MAX;
		end else begin
			chans_eff = CHC_W'(chan_cnt_q);
		end
	end

	always_comb begin
		if (max_pts_q == '0) begin
			limit_eff = PTC_W'(1);
		end else if (PTC_W'(max_pts_q) > PT_MAX) begin
			limit_eff = PT_MAX;
		end else begin
			limit_eff = PTC_W'(max_pts_q);
		end
	end

	assign pos_inc    = CHC_W'(pos_q) + CHC_W'(1);
	assign frame_done = (pos_inc >= chans_eff);
	// The frame count wraps at 32 bits like the register it compares with;
	// a zero frames_per_point acts as one.
	assign frames_inc  = frames_q + FPP_W'(1);
	assign bucket_full = frame_done &&
	                     ((fpp_q == '0) ? (frames_inc != '0) : (frames_inc >= fpp_q));
	assign emit        = bucket_full || eot_s1;
	assign pts_inc     = PTC_W'(pts_q) + PTC_W'(1);
	assign fin         = eot_s1 || (pts_inc >= limit_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q       <= '0;
			pos_q        <= '0;
			frames_q     <= '0;
			pts_q        <= '0;
			track_done_q <= 1'b0;
		end else if (step) begin
			if (track_done_q) begin
				// Swallowed sample; only the end of the track frees the block.
				if (eot_s1) begin
					track_done_q <= 1'b0;
					pts_q        <= '0;
				end
			end else if (emit && eot_s1) begin
				peak_q   <= '0;
				pos_q    <= '0;
				frames_q <= '0;
				pts_q    <= '0;
			end else if (emit && fin) begin
				peak_q       <= '0;
				pos_q        <= '0;
				frames_q     <= '0;
				pts_q        <= pts_inc[PTS_W-1:0];
				track_done_q <= 1'b1;
			end else if (emit) begin
				// Full bucket in mid-track; the frame has just wrapped.
				peak_q   <= '0;
				pos_q    <= '0;
				frames_q <= '0;
				pts_q    <= pts_inc[PTS_W-1:0];
			end else begin
				peak_q <= peak_new;
				if (frame_done) begin
					pos_q    <= '0;
					frames_q <= frames_inc;
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && !track_done_q && emit) begin
			out_valid_q <= 1'b1;
		end else if (points.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !track_done_q && emit) begin
			out_peak_q  <= peak_new;
			out_final_q <= fin;
		end
	end

	assign points.valid       = out_valid_q;
	assign points.peak_level  = out_peak_q;
	assign points.final_point = out_final_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_peak_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_peak_q <= FULL_SCALE))
		else $error("peak point above full scale");

	a_done_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		track_done_q |-> (peak_q == '0 && pos_q == '0 && frames_q == '0))
		else $error("bucket state left over after the point limit");

	a_eot_gives_final: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !track_done_q && eot_s1) |=> (out_valid_q && out_final_q))
		else $error("end of track did not produce a final point");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CHC_W'(pos_q) < CH_MAX)
		else $error("channel position beyond the channel limit");

endmodule

`default_nettype wire

@@ sim/waveform_peak_decimator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of waveform_peak_decimator: drives samples and register writes,
// predicts every peak point and compares it with what the block sends.
// Depends on wpd_pkg, the interfaces in hdl/wpd_if.sv and the block itself.

module waveform_peak_decimator_tb;
	import wpd_pkg::*;

	localparam int MAX_CH        = DEFAULT_MAX_CHANNELS;
	localparam int PT_LIMIT      = DEFAULT_POINT_LIMIT;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 4;
	// Watchdog limit, far beyond the slowest correct run.
	localparam longint unsigned WATCHDOG_NS = 64'd4_800_000;

	// Expected point as the predictor works it out.
	typedef struct packed {
		peak_t level;
		logic  last;
	} peak_point_t;

	// The scoreboard keeps its own copy of the registers and of the track state, works out the
	// point (if any) that each accepted sample causes and holds it until the block sends one.
	class peak_scoreboard;
		fmt_t        fmt;
		int unsigned chan_reg, fpp_reg, maxpts_reg;
		int unsigned peak, chan_pos, frames, points;
		bit          done;
		peak_point_t due_points[$];
		int unsigned errors, folded, swallowed, points_seen, finals_seen, reg_writes;

		function new();
			fmt        = RST_SAMPLE_FORMAT;
			chan_reg   = RST_CHANNEL_COUNT;
			fpp_reg    = RST_FRAMES_PER_POINT;
			maxpts_reg = RST_MAX_POINTS;
			restart_track();
		endfunction

		function void restart_track();
			peak     = 0;
			chan_pos = 0;
			frames   = 0;
			points   = 0;
			done     = 1'b0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t ns: %s", $time, msg);
		endfunction

		function int unsigned pending();
			return due_points.size();
		endfunction

		function void write_reg(reg_index_t idx, cfg_data_t d);
			reg_writes++;
			case (idx)
				REG_SAMPLE_FORMAT:    fmt        = fmt_t'(d[FMT_W-1:0]);
				REG_CHANNEL_COUNT:    chan_reg   = d[CHAN_W-1:0];
				REG_FRAMES_PER_POINT: fpp_reg    = d[FPP_W-1:0];
				REG_MAX_POINTS:       maxpts_reg = d[MAXPTS_W-1:0];
				default: ;
			endcase
		endfunction

		// Absolute amplitude in unsigned Q1.16, truncated toward zero.
		function int unsigned magnitude(word_t w);
			int unsigned b, ex, sh;
			logic [31:0] m;
			case (fmt)
				FMT_U8: begin
					b = w[7:0];
					return ((b >= U8_MIDPOINT) ? b - U8_MIDPOINT : U8_MIDPOINT - b) << 9;
				end
				FMT_S16: begin
					m = {16'd0, w[15:0]};
					if (w[15])
						m = 32'h1_0000 - m;
					return m << 1;
				end
				FMT_S32: begin
					m = w;
					if (m[31])
						m = 32'd0 - m;
					return m >> 15;
				end
				default: begin
					ex = w[30:23];
					if (ex == F32_EXP_SPECIAL)
						return (w[22:0] != 0) ? 0 : FULL_SCALE;
					if (ex >= F32_EXP_ONE)
						return FULL_SCALE;
					if (ex == 0)
						return 0;
					sh = F32_SHIFT_BASE - ex;
					if (sh > 31)
						return 0;
					return {8'd0, 1'b1, w[22:0]} >> sh;
				end
			endcase
		endfunction

		function void note_sample(word_t w, logic eot);
			int unsigned chans, fpp, lim, amp;
			bit emit, fin;
			chans = (chan_reg == 0) ? 1 : chan_reg;
			if (chans > MAX_CH)
				chans = MAX_CH;
			fpp = (fpp_reg == 0) ? 1 : fpp_reg;
			lim = (maxpts_reg == 0) ? 1 : maxpts_reg;
			if (lim > PT_LIMIT)
				lim = PT_LIMIT;
			emit = 1'b0;
			fin  = 1'b0;
			if (done) begin
				swallowed++;
				if (eot)
					restart_track();
				return;
			end
			folded++;
			amp = magnitude(w);
			if (amp > peak)
				peak = amp;
			chan_pos++;
			if (chan_pos >= chans) begin
				chan_pos = 0;
				frames++;
				if (frames >= fpp)
					emit = 1'b1;
			end
			if (eot) begin
				emit = 1'b1;
				fin  = 1'b1;
			end
			if (!emit)
				return;
			points++;
			if (points >= lim)
				fin = 1'b1;
			due_points.push_back('{level: peak_t'(peak), last: fin});
			if (eot) begin
				restart_track();
			end else if (fin) begin
				peak     = 0;
				chan_pos = 0;
				frames   = 0;
				done     = 1'b1;
			end else begin
				peak   = 0;
				frames = 0;
			end
		endfunction

		function void check_point(peak_t level, logic fin);
			peak_point_t e;
			points_seen++;
			if (fin)
				finals_seen++;
			if (due_points.size() == 0) begin
				flag($sformatf("point with no expectation waiting: level %0d final %0b",
					level, fin));
				return;
			end
			e = due_points.pop_front();
			if (e.level !== level || e.last !== fin)
				flag($sformatf("point mismatch: expected level %0d final %0b, got level %0d final %0b",
					e.level, e.last, level, fin));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wpd_cfg_if    cfg_bus ();
	wpd_sample_if sample_bus ();
	wpd_point_if  point_bus ();

	waveform_peak_decimator #(
		.MAX_CHANNELS(MAX_CH),
		.POINT_LIMIT (PT_LIMIT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.samples(sample_bus),
		.points (point_bus)
	);

	peak_scoreboard scoreboard = new();

	// When steady is set neither side idles. A non-zero hold_req asks the point receiver to
	// hold off for that many cycles, which it counts itself.
	bit          steady;
	int unsigned hold_req;
	int unsigned holds_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Every transaction is seen here, at the edge where it happens. All drivers use nonblocking
	// assignments, so the values read are those from before the edge whatever the order of
	// processes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				scoreboard.write_reg(reg_index_t'(cfg_bus.index), cfg_bus.data);
			if (sample_bus.valid && sample_bus.ready)
				scoreboard.note_sample(sample_bus.sample_word, sample_bus.end_of_track);
			if (point_bus.valid && point_bus.ready)
				scoreboard.check_point(point_bus.peak_level, point_bus.final_point);
		end
	end

	// Point receiver: ready most cycles, with random stalls, and one long hold-off on request
	// so that the output register and the sample register both fill and the input stalls.
	initial begin
		int unsigned held;
		point_bus.ready <= 1'b0;
		forever begin
			if (hold_req != 0) begin
				held     = hold_req;
				hold_req = 0;
				repeat (held) begin
					point_bus.ready <= 1'b0;
					@(posedge clk);
				end
				holds_done++;
			end else begin
				point_bus.ready <= steady || ($urandom_range(99) >= 7);
				@(posedge clk);
			end
		end
	end

	// Offers one sample, with a random idle gap first, and returns at the edge where the
	// transaction happens. Valid stays high so that the next sample can follow at once.
	task automatic send_sample(input word_t w, input logic eot);
		while (!steady && $urandom_range(99) < 7) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid        <= 1'b1;
		sample_bus.sample_word  <= w;
		sample_bus.end_of_track <= eot;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
	endtask

	// Stops offering samples and waits until every predicted point has come out. A sample that
	// causes no point may still be in the pipeline then, so a settling period is let pass.
	task automatic drain();
		int unsigned n;
		sample_bus.valid <= 1'b0;
		n = 0;
		while (scoreboard.pending() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input cfg_data_t d);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= d;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
	endtask

	// Random bits above a register's width, which the block must ignore.
	function automatic cfg_data_t with_junk(input cfg_data_t v, input int w);
		cfg_data_t junk;
		junk = $urandom_range(1) ? (($urandom() >> w) << w) : '0;
		return junk | v;
	endfunction

	// All four registers are written on an idle block. Track state carries over, so a phase
	// that stopped in the middle of a bucket continues under the new setting.
	task automatic configure(input fmt_t f, input cfg_data_t chans, input cfg_data_t fpp,
			input cfg_data_t maxpts);
		drain();
		write_reg(REG_SAMPLE_FORMAT, with_junk(cfg_data_t'(f), FMT_W));
		write_reg(REG_CHANNEL_COUNT, with_junk(chans, CHAN_W));
		write_reg(REG_FRAMES_PER_POINT, fpp);
		write_reg(REG_MAX_POINTS, with_junk(maxpts, MAXPTS_W));
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random sample word for the current format: mostly random bits, sometimes an extreme value near full scale or
	// zero, and for float32 mostly exponents near the Q1.16 window.
	function automatic word_t pick_sample();
		word_t       w;
		int unsigned sel;
		w   = $urandom();
		sel = $urandom_range(99);
		if (sel < 12) begin
			case (scoreboard.fmt)
				FMT_U8:  w[7:0] = ($urandom_range(1)) ? 8'h00 : 8'h80;
				FMT_S16: w[15:0] = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
				FMT_S32: w = ($urandom_range(1)) ? 32'h8000_0000 : 32'hFFFF_FFFF;
				default: w[30:23] = ($urandom_range(1)) ? F32_EXP_SPECIAL : 8'd0;
			endcase
		end else if (scoreboard.fmt == FMT_F32 && sel < 85) begin
			w[30:23] = 8'($urandom_range(F32_EXP_MIN - 5, F32_EXP_ONE + 1));
		end
		return w;
	endfunction

	// Tracks of random length closed by end_of_track, with the odd early end_of_track and the
	// odd track left open, until the given number of samples has been accepted, whether folded
	// into peaks or swallowed.
	task automatic run_tracks(input int unsigned budget);
		int unsigned start, len, k;
		logic        eot;
		start = scoreboard.folded + scoreboard.swallowed;
		while (scoreboard.folded + scoreboard.swallowed - start < budget) begin
			len = ($urandom_range(99) < 70) ? $urandom_range(1, 24) : $urandom_range(25, 120);
			for (k = 0; k < len; k++) begin
				if (k == len - 1)
					eot = ($urandom_range(9) != 0);
				else
					eot = ($urandom_range(99) < 2);
				send_sample(pick_sample(), eot);
			end
		end
	endtask

	initial begin
		int unsigned target;
		cfg_data_t   fpp, maxpts;
		steady                  = 1'b0;
		hold_req                = 0;
		holds_done              = 0;
		arst_n                  <= 1'b0;
		cfg_bus.valid           <= 1'b0;
		cfg_bus.index           <= REG_SAMPLE_FORMAT;
		cfg_bus.data            <= '0;
		sample_bus.valid        <= 1'b0;
		sample_bus.sample_word  <= '0;
		sample_bus.end_of_track <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first at the reset setting: 16-bit stereo, one frame per point.
		send_sample(32'h0000_8000, 1'b0);   // most negative 16-bit value, full scale
		send_sample(32'h0000_7FFF, 1'b0);
		send_sample(32'hFFFF_0000, 1'b0);   // upper bits must be ignored
		send_sample(32'h0000_FFFF, 1'b0);   // minus one
		send_sample(32'h0000_1234, 1'b1);   // frame cut short by the end of the track

		// Unsigned 8-bit mono, two frames per point: both extremes, a flushed half bucket, and a
		// sample that fills the bucket and ends the track at once.
		configure(FMT_U8, 1, 2, RST_MAX_POINTS);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0080, 1'b1);
		send_sample(32'h0000_007F, 1'b0);
		send_sample(32'h0000_0081, 1'b1);

		// Signed 32-bit with a limit of two points: the second point closes the track, the rest
		// is swallowed, and the swallowed end_of_track readies the next track.
		configure(FMT_S32, 1, 1, 2);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h1234_5678, 1'b0);
		send_sample(32'h0000_0005, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b1);

		// float32: infinities, NaN, exactly one, just below one, a subnormal, the bottom of the
		// exponent window, the smallest value that still counts, and minus one half.
		configure(FMT_F32, 1, 1, PT_LIMIT);
		send_sample(32'h7F80_0000, 1'b0);
		send_sample(32'hFF80_0000, 1'b0);
		send_sample(32'h7FC0_0001, 1'b0);
		send_sample(32'h3F80_0000, 1'b0);
		send_sample(32'h3F7F_FFFF, 1'b0);
		send_sample(32'h0000_0001, 1'b0);
		send_sample(32'h3380_0000, 1'b0);
		send_sample(32'h3780_0000, 1'b0);
		send_sample(32'hBF00_0000, 1'b1);

		// Random part. Corner settings come first: zero registers acting as one, channel counts
		// and point limits above the parameters, and a bucket that never fills.
		target = scoreboard.folded + scoreboard.swallowed + RANDOM_ITEMS;
		configure(FMT_U8, 1, 1, PT_LIMIT);
		run_tracks(100);
		configure(FMT_S16, MAX_CH, 3, 5);
		run_tracks(100);
		configure(FMT_S32, 0, 0, 0);
		run_tracks(80);
		configure(FMT_F32, 15, 2, 2047);
		run_tracks(100);
		configure(FMT_F32, 3, 32'hFFFF_FFFF, RST_MAX_POINTS);
		run_tracks(100);

		// A stretch with no idling on either side.
		steady = 1'b1;
		configure(FMT_S16, 2, 1, PT_LIMIT);
		run_tracks(150);
		steady = 1'b0;

		// Long hold-off on the point side while samples keep coming, one point per sample.
		configure(FMT_U8, 1, 1, PT_LIMIT);
		hold_req = HOLD_CYCLES;
		run_tracks(100);

		// Random settings for the rest, mostly small buckets and limits that are reached.
		while (scoreboard.folded + scoreboard.swallowed < target) begin
			case ($urandom_range(99) / 20)
				0, 1, 2: fpp = $urandom_range(0, 6);
				3:       fpp = $urandom_range(7, 40);
				default: fpp = $urandom();
			endcase
			maxpts = ($urandom_range(1)) ? $urandom_range(0, 12) : $urandom_range(13, 2047);
			configure(fmt_t'($urandom_range(3)), $urandom_range(0, 15), fpp, maxpts);
			run_tracks($urandom_range(60, 140));
		end

		drain();
		if (scoreboard.pending() != 0)
			scoreboard.flag($sformatf("%0d expected points never arrived",
				scoreboard.pending()));

		$display("Run covered %0d samples folded into peaks and %0d swallowed after a track end,",
			scoreboard.folded, scoreboard.swallowed);
		$display("%0d points checked (%0d closing a track), %0d register writes, %0d hold-offs.",
			scoreboard.points_seen, scoreboard.finals_seen, scoreboard.reg_writes, holds_done);
		if (scoreboard.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#(WATCHDOG_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
